// ----- src/jse_pkg.sv -----
`timescale 1ns / 1ps

package jse_pkg;

	// One input request: a source byte plus string framing.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       string_start;
		logic       string_end;
	} in_item_t;

	// One result request: a byte of the JSON literal.
	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_item;
	} out_item_t;

	// Token kinds that the classifier hands to the expander.
	typedef enum logic [1:0] {
		TOK_QUOTE,
		TOK_RAW,
		TOK_U00,
		TOK_BSL
	} tok_kind_t;

	// A classified token; value is the byte to copy, to hex-encode, or to put after a backslash.
	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] value;
		logic       last;
	} token_t;

	localparam int unsigned TOK_FIFO_DEPTH = 4;

endpackage

// ----- src/json_string_escaper_utf8.sv -----
`timescale 1ns / 1ps

// JSON string escaper with UTF-8 checking.
// Input side is a queue: drive item and raise push; the request is taken on a
// rising edge where push is high and full is low. Each request carries one
// source byte (or none), with string_start and string_end framing a string.
// Result side is a queue too: while empty is low, result holds the oldest byte
// of the JSON literal, and pop on a rising edge takes it. last_of_item marks
// the final byte that a request caused.
// While the receiver pops, throughput is one output byte per cycle, set by
// the expander in the back end; a request that gives one byte sustains one
// request per cycle. The front end issues its tokens one at a time (escapes,
// quotes and each byte of a completed multi-byte sequence), and the four-entry
// token queue between the two halves absorbs short bursts. When the receiver
// stalls, the result register holds, the token queue fills, and full rises
// on the input. Reset clears all control state and any open string; no
// clearing pass.
module json_string_escaper_utf8 #(
	parameter int unsigned TOK_DEPTH = jse_pkg::TOK_FIFO_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  jse_pkg::in_item_t  item,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output jse_pkg::out_item_t result
);

	logic            tok_push;
	jse_pkg::token_t tok_w;
	logic            tok_full;
	logic            tok_pop;
	jse_pkg::token_t tok_r;
	logic            tok_nonempty;

	jse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.tok_push (tok_push),
		.tok      (tok_w),
		.tok_full (tok_full)
	);

	jse_fifo #(
		.DEPTH (TOK_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tok_push),
		.push_data (tok_w),
		.full      (tok_full),
		.pop       (tok_pop),
		.pop_data  (tok_r),
		.nonempty  (tok_nonempty)
	);

	jse_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_nonempty (tok_nonempty),
		.tok_in       (tok_r),
		.tok_pop      (tok_pop),
		.empty        (empty),
		.pop          (pop),
		.result       (result)
	);

endmodule

// ----- src/jse_front.sv -----
`timescale 1ns / 1ps

module jse_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jse_pkg::in_item_t item,
	output logic              full,
	output logic              tok_push,
	output jse_pkg::token_t   tok,
	input  logic              tok_full
);

	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] LEAD_ED   = 8'hED;
	localparam logic [7:0] SEC_E0_LO = 8'hA0;
	localparam logic [7:0] SEC_ED_HI = 8'h9F;
	localparam logic [7:0] SEC_F0_LO = 8'h90;
	localparam logic [7:0] SEC_F4_HI = 8'h8F;
	localparam logic [7:0] CTRL_LIM  = 8'h20;
	localparam logic [7:0] ASCII_LIM = 8'h80;

	localparam logic [7:0] B_BSL  = 8'h5C;
	localparam logic [7:0] B_QUOT = 8'h22;
	localparam logic [7:0] B_LT   = 8'h3C;
	localparam logic [7:0] B_GT   = 8'h3E;
	localparam logic [7:0] B_AMP  = 8'h26;
	localparam logic [7:0] B_LF   = 8'h0A;
	localparam logic [7:0] B_CR   = 8'h0D;
	localparam logic [7:0] B_TAB  = 8'h09;
	localparam logic [7:0] C_N    = 8'h6E;
	localparam logic [7:0] C_R    = 8'h72;
	localparam logic [7:0] C_T    = 8'h74;

	typedef enum logic [1:0] {
		PH_START,
		PH_FEED,
		PH_END
	} phase_t;

	function automatic logic is_lead(input logic [7:0] b);
		return (b >= LEAD2_LO) && (b <= LEAD4_HI);
	endfunction

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		if (b <= LEAD2_HI) begin
			len = 3'd2;
		end else if (b <= LEAD3_HI) begin
			len = 3'd3;
		end else begin
			len = 3'd4;
		end
		return len;
	endfunction

	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
		logic ok;
		ok = 1'b1;
		if (lead == LEAD3_LO && b < SEC_E0_LO) ok = 1'b0;
		if (lead == LEAD_ED && b > SEC_ED_HI) ok = 1'b0;
		if (lead == LEAD4_LO && b < SEC_F0_LO) ok = 1'b0;
		if (lead == LEAD4_HI && b > SEC_F4_HI) ok = 1'b0;
		return ok;
	endfunction

	// Current request and UTF-8 gathering state.
	logic              cur_valid_q;
	jse_pkg::in_item_t cur_q;
	phase_t            phase_q, phase_n;
	logic [7:0]        held_q [4];
	logic [7:0]        held_n [4];
	logic [2:0]        cnt_q, cnt_n;
	logic [2:0]        exp_q, exp_n;
	logic [1:0]        ptr_q, ptr_n;
	logic              open_q, open_n;
	logic              flush_q, flush_n;
	logic              raw_q, raw_n;

	logic              tok_valid;
	logic              done;
	logic              advance;
	logic              accept;
	logic              idle_done;
	logic              flush_fin;
	logic              cont_ok;
	phase_t            eff;
	logic [7:0]        b;

	assign b = cur_q.data_byte;
	assign flush_fin = (({1'b0, ptr_q} + 3'd1) == cnt_q);
	assign cont_ok = (b[7:6] == 2'b10) && ((cnt_q != 3'd1) || second_ok(held_q[0], b));

	// Produce at most one token per cycle for the current request.
	always_comb begin
		tok_valid = 1'b0;
		tok = '{kind: jse_pkg::TOK_RAW, value: 8'h00, last: 1'b0};
		done = 1'b0;
		idle_done = 1'b0;
		phase_n = phase_q;
		held_n = held_q;
		cnt_n = cnt_q;
		exp_n = exp_q;
		ptr_n = ptr_q;
		open_n = open_q;
		flush_n = flush_q;
		raw_n = raw_q;
		eff = phase_q;

		// Skip over steps that yield nothing for this request.
		if (eff == PH_START && !cur_q.string_start) begin
			if (!open_q) idle_done = 1'b1;
			else eff = PH_FEED;
		end
		if (!idle_done && eff == PH_FEED && !cur_q.byte_present) begin
			if (cur_q.string_end) eff = PH_END;
			else idle_done = 1'b1;
		end

		if (cur_valid_q) begin
			if (idle_done) begin
				done = 1'b1;
			end else begin
				unique case (eff)
					PH_START: begin
						if (cnt_q != 3'd0) begin
							// A new string drops the held bytes as escapes.
							tok_valid = 1'b1;
							tok.kind = jse_pkg::TOK_U00;
							tok.value = held_q[ptr_q];
							if (flush_fin) begin
								cnt_n = 3'd0;
								exp_n = 3'd0;
								ptr_n = 2'd0;
							end else begin
								ptr_n = ptr_q + 2'd1;
							end
						end else begin
							tok_valid = 1'b1;
							tok.kind = jse_pkg::TOK_QUOTE;
							tok.last = !((cur_q.byte_present && !is_lead(b)) ||
								cur_q.string_end);
							open_n = 1'b1;
							if (cur_q.byte_present) phase_n = PH_FEED;
							else if (cur_q.string_end) phase_n = PH_END;
							else done = 1'b1;
						end
					end
					PH_FEED: begin
						priority if (flush_q) begin
							// Rest of a failed sequence, then the byte is judged fresh.
							tok_valid = 1'b1;
							tok.kind = jse_pkg::TOK_U00;
							tok.value = held_q[ptr_q];
							tok.last = flush_fin && is_lead(b) && !cur_q.string_end;
							if (flush_fin) begin
								cnt_n = 3'd0;
								exp_n = 3'd0;
								ptr_n = 2'd0;
								flush_n = 1'b0;
							end else begin
								ptr_n = ptr_q + 2'd1;
							end
						end else if (raw_q) begin
							// Copy out a completed sequence.
							tok_valid = 1'b1;
							tok.kind = jse_pkg::TOK_RAW;
							tok.value = held_q[ptr_q];
							if (flush_fin) begin
								cnt_n = 3'd0;
								exp_n = 3'd0;
								ptr_n = 2'd0;
								raw_n = 1'b0;
								tok.last = !cur_q.string_end;
								if (cur_q.string_end) phase_n = PH_END;
								else done = 1'b1;
							end else begin
								ptr_n = ptr_q + 2'd1;
							end
						end else if (cnt_q == 3'd0) begin
							// Classify a fresh byte.
							tok_valid = 1'b1;
							tok.value = b;
							unique case (b)
								B_BSL: tok.kind = jse_pkg::TOK_BSL;
								B_QUOT: tok.kind = jse_pkg::TOK_BSL;
								B_LF: begin
									tok.kind = jse_pkg::TOK_BSL;
									tok.value = C_N;
								end
								B_CR: begin
									tok.kind = jse_pkg::TOK_BSL;
									tok.value = C_R;
								end
								B_TAB: begin
									tok.kind = jse_pkg::TOK_BSL;
									tok.value = C_T;
								end
								B_LT, B_GT, B_AMP: tok.kind = jse_pkg::TOK_U00;
								default: begin
									priority if (b < CTRL_LIM) begin
										tok.kind = jse_pkg::TOK_U00;
									end else if (b < ASCII_LIM) begin
										tok.kind = jse_pkg::TOK_RAW;
									end else if (is_lead(b)) begin
										tok_valid = 1'b0;
										held_n[0] = b;
										cnt_n = 3'd1;
										exp_n = lead_len(b);
									end else begin
										tok.kind = jse_pkg::TOK_U00;
									end
								end
							endcase
							tok.last = !cur_q.string_end;
							if (cur_q.string_end) phase_n = PH_END;
							else done = 1'b1;
						end else if (!cont_ok) begin
							// Broken sequence: escape the lead first.
							tok_valid = 1'b1;
							tok.kind = jse_pkg::TOK_U00;
							tok.value = held_q[ptr_q];
							tok.last = flush_fin && is_lead(b) && !cur_q.string_end;
							if (flush_fin) begin
								cnt_n = 3'd0;
								exp_n = 3'd0;
								ptr_n = 2'd0;
							end else begin
								ptr_n = ptr_q + 2'd1;
								flush_n = 1'b1;
							end
						end else if ((cnt_q + 3'd1) >= exp_q) begin
							// Sequence complete: store the byte and start copying.
							held_n[cnt_q[1:0]] = b;
							cnt_n = cnt_q + 3'd1;
							tok_valid = 1'b1;
							tok.kind = jse_pkg::TOK_RAW;
							tok.value = held_q[0];
							ptr_n = 2'd1;
							raw_n = 1'b1;
						end else begin
							held_n[cnt_q[1:0]] = b;
							cnt_n = cnt_q + 3'd1;
							if (cur_q.string_end) phase_n = PH_END;
							else done = 1'b1;
						end
					end
					PH_END: begin
						tok_valid = 1'b1;
						if (cnt_q != 3'd0) begin
							// A truncated sequence at the end is escaped byte by byte.
							tok.kind = jse_pkg::TOK_U00;
							tok.value = held_q[ptr_q];
							if (flush_fin) begin
								cnt_n = 3'd0;
								exp_n = 3'd0;
								ptr_n = 2'd0;
							end else begin
								ptr_n = ptr_q + 2'd1;
							end
						end else begin
							tok.kind = jse_pkg::TOK_QUOTE;
							tok.last = 1'b1;
							open_n = 1'b0;
							done = 1'b1;
						end
					end
					default: done = 1'b1;
				endcase
			end
		end
	end

	assign advance  = cur_valid_q && (!tok_valid || !tok_full);
	assign full     = cur_valid_q && !(advance && done);
	assign accept   = push && !full;
	assign tok_push = cur_valid_q && tok_valid && !tok_full;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			phase_q <= PH_START;
			cnt_q <= 3'd0;
			exp_q <= 3'd0;
			ptr_q <= 2'd0;
			open_q <= 1'b0;
			flush_q <= 1'b0;
			raw_q <= 1'b0;
		end else begin
			if (advance) begin
				cnt_q <= cnt_n;
				exp_q <= exp_n;
				ptr_q <= ptr_n;
				open_q <= open_n;
				flush_q <= flush_n;
				raw_q <= raw_n;
			end
			// A newly taken request always begins at its start step.
			if (accept) begin
				phase_q <= PH_START;
			end else if (advance) begin
				phase_q <= phase_n;
			end
			if (accept) begin
				cur_valid_q <= 1'b1;
			end else if (advance && done) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	// Payload: current request and held bytes.
	always_ff @(posedge clk) begin
		if (accept) cur_q <= item;
		if (advance) held_q <= held_n;
	end

endmodule

// ----- src/jse_fifo.sv -----
`timescale 1ns / 1ps

module jse_fifo #(
	parameter int unsigned DEPTH = jse_pkg::TOK_FIFO_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jse_pkg::token_t push_data,
	output logic            full,
	input  logic            pop,
	output jse_pkg::token_t pop_data,
	output logic            nonempty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	jse_pkg::token_t mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == FULL_CNT);
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign pop_data = mem_q[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == LAST_SLOT) ? '0 : wr_q + PW'(1);
			if (do_pop) rd_q <= (rd_q == LAST_SLOT) ? '0 : rd_q + PW'(1);
			if (do_push && !do_pop) count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

	// Token storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule

// ----- src/jse_back.sv -----
`timescale 1ns / 1ps

module jse_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tok_nonempty,
	input  jse_pkg::token_t     tok_in,
	output logic                tok_pop,
	output logic                empty,
	input  logic                pop,
	output jse_pkg::out_item_t  result
);

	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_U    = 8'h75;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] HEX_LC  = 8'h57;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (CH_ZERO + {4'h0, n}) : (HEX_LC + {4'h0, n});
	endfunction

	jse_pkg::token_t    tok_q;
	logic               tok_valid_q;
	logic [2:0]         idx_q;
	jse_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic [2:0]         len;
	logic [7:0]         ch;
	logic               final_char;
	logic               step;
	logic               out_taken;

	// Expansion length and the byte at the current position.
	always_comb begin
		len = 3'd1;
		ch = tok_q.value;
		unique case (tok_q.kind)
			jse_pkg::TOK_QUOTE: ch = CH_QUOT;
			jse_pkg::TOK_RAW: ch = tok_q.value;
			jse_pkg::TOK_BSL: begin
				len = 3'd2;
				ch = (idx_q == 3'd0) ? CH_BSL : tok_q.value;
			end
			jse_pkg::TOK_U00: begin
				len = 3'd6;
				unique case (idx_q)
					3'd0: ch = CH_BSL;
					3'd1: ch = CH_U;
					3'd2, 3'd3: ch = CH_ZERO;
					3'd4: ch = hex_char(tok_q.value[7:4]);
					default: ch = hex_char(tok_q.value[3:0]);
				endcase
			end
			default: ch = tok_q.value;
		endcase
	end

	assign final_char = (idx_q == (len - 3'd1));
	assign out_taken  = pop && out_valid_q;
	assign step       = tok_valid_q && (!out_valid_q || out_taken);
	assign tok_pop    = tok_nonempty && (!tok_valid_q || (step && final_char));
	assign empty      = !out_valid_q;
	assign result     = out_q;

	// Token and output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
			idx_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_pop) tok_valid_q <= 1'b1;
			else if (step && final_char) tok_valid_q <= 1'b0;
			if (step) begin
				idx_q <= final_char ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (tok_pop) tok_q <= tok_in;
		if (step) begin
			out_q.out_char <= ch;
			out_q.last_of_item <= tok_q.last && final_char;
		end
	end

endmodule

// ----- sim/json_literal_checker.sv -----
`timescale 1ns / 1ps

// Watches both queue ports of the escaper. It predicts the JSON literal bytes of
// every accepted request and compares them in order with the bytes that are
// popped. Both ports are sampled on the falling edge. All signals change only on
// the rising edge, so a handshake seen there completes at the next rising edge.
module json_literal_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  jse_pkg::in_item_t  item,
	input  logic               full,
	input  logic               empty,
	input  logic               pop,
	input  jse_pkg::out_item_t result,
	output int unsigned        mismatch_count,
	output int unsigned        outstanding
);

	// Characters that take part in escapes.
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h61;

	// Predictor state: the partial multi-byte sequence and the framing.
	logic [7:0]         utf8_hold [4];
	logic [2:0]         utf8_count;
	logic [2:0]         utf8_len;
	logic               string_open;
	jse_pkg::out_item_t literal_q [$];

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		return (nib < 4'd10) ? (CH_ZERO + {4'h0, nib}) : (CH_A + {4'h0, nib} - 8'd10);
	endfunction

	// The second byte of a sequence must not make an overlong form, a surrogate, or a code point above U+10FFFF.
	function automatic bit second_byte_ok(input logic [7:0] lead, input logic [7:0] ch);
		if (lead == 8'hE0 && ch < 8'hA0) return 1'b0;
		if (lead == 8'hED && ch > 8'h9F) return 1'b0;
		if (lead == 8'hF0 && ch < 8'h90) return 1'b0;
		if (lead == 8'hF4 && ch > 8'h8F) return 1'b0;
		return 1'b1;
	endfunction

	task automatic put_char(input logic [7:0] ch);
		jse_pkg::out_item_t r;
		r.out_char     = ch;
		r.last_of_item = 1'b0;
		literal_q = {literal_q, r};
	endtask

	task automatic put_pair(input logic [7:0] ch);
		put_char(CH_BSL);
		put_char(ch);
	endtask

	// A byte written as a six-character \u00xx escape with lowercase hex.
	task automatic put_u00(input logic [7:0] ch);
		put_char(CH_BSL);
		put_char(CH_U);
		put_char(CH_ZERO);
		put_char(CH_ZERO);
		put_char(hex_digit(ch[7:4]));
		put_char(hex_digit(ch[3:0]));
	endtask

	// Held bytes of an unfinished sequence each become an escape.
	task automatic flush_held();
		for (int i = 0; i < utf8_count; i++)
			put_u00(utf8_hold[i[1:0]]);
		utf8_count = 3'd0;
		utf8_len   = 3'd0;
	endtask

	// A byte that no open sequence claims.
	task automatic judge_fresh(input logic [7:0] ch);
		case (ch)
			CH_BSL:                put_pair(CH_BSL);
			CH_QUOTE:              put_pair(CH_QUOTE);
			CH_LT, CH_GT, CH_AMP:  put_u00(ch);
			CH_LF:                 put_pair(CH_N);
			CH_CR:                 put_pair(CH_R);
			CH_TAB:                put_pair(CH_T);
			default: begin
				if (ch < 8'h20) begin
					put_u00(ch);
				end else if (ch < 8'h80) begin
					put_char(ch);
				end else if (ch >= 8'hC2 && ch <= 8'hF4) begin
					// A valid lead byte opens a sequence of 2, 3 or 4 bytes.
					if (ch <= 8'hDF)
						utf8_len = 3'd2;
					else if (ch <= 8'hEF)
						utf8_len = 3'd3;
					else
						utf8_len = 3'd4;
					utf8_hold[0] = ch;
					utf8_count   = 3'd1;
				end else begin
					put_u00(ch);
				end
			end
		endcase
	endtask

	task automatic feed_byte(input logic [7:0] ch);
		bit ok;
		if (utf8_count == 0 || utf8_count >= utf8_len) begin
			if (utf8_count != 0)
				flush_held();
			judge_fresh(ch);
		end else begin
			ok = (ch[7:6] == 2'b10);
			if (ok && utf8_count == 1)
				ok = second_byte_ok(utf8_hold[0], ch);
			if (!ok) begin
				flush_held();
				judge_fresh(ch);
			end else begin
				utf8_hold[utf8_count[1:0]] = ch;
				utf8_count++;
				// A complete sequence is copied unchanged.
				if (utf8_count >= utf8_len) begin
					for (int i = 0; i < utf8_count; i++)
						put_char(utf8_hold[i[1:0]]);
					utf8_count = 3'd0;
					utf8_len   = 3'd0;
				end
			end
		end
	endtask

	// Appends the bytes that one request causes and marks the last of them.
	task automatic predict_literal(input jse_pkg::in_item_t req);
		int unsigned mark;
		mark = literal_q.size();
		if (req.string_start || string_open) begin
			if (req.string_start) begin
				flush_held();
				put_char(CH_QUOTE);
				string_open = 1'b1;
			end
			if (req.byte_present)
				feed_byte(req.data_byte);
			if (req.string_end) begin
				flush_held();
				put_char(CH_QUOTE);
				string_open = 1'b0;
			end
			if (literal_q.size() > mark)
				literal_q[literal_q.size() - 1].last_of_item = 1'b1;
		end
	endtask

	// Predict on accepted requests, compare on accepted results.
	always @(negedge clk) begin
		jse_pkg::out_item_t want;
		if (!arst_n) begin
			utf8_hold      = '{default: 8'h00};
			utf8_count     = 3'd0;
			utf8_len       = 3'd0;
			string_open    = 1'b0;
			mismatch_count = 0;
			literal_q.delete();
		end else begin
			if (push && !full)
				predict_literal(item);
			if (pop && !empty) begin
				if (literal_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, got char %h last %b",
						$time, result.out_char, result.last_of_item);
					mismatch_count++;
				end else begin
					want = literal_q.pop_front();
					if (result.out_char !== want.out_char) begin
						$display("%0t: out_char mismatch: expected %h, got %h",
							$time, want.out_char, result.out_char);
						mismatch_count++;
					end
					if (result.last_of_item !== want.last_of_item) begin
						$display("%0t: last_of_item mismatch: expected %b, got %b",
							$time, want.last_of_item, result.last_of_item);
						mismatch_count++;
					end
				end
			end
		end
		outstanding = literal_q.size();
	end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               push   = 1'b0;
	jse_pkg::in_item_t  item   = '0;
	logic               pop    = 1'b0;
	logic               full;
	logic               empty;
	jse_pkg::out_item_t result;
	int unsigned        mismatch_count;
	int unsigned        outstanding;

	// Stimulus bookkeeping.
	logic [7:0]  text_q [$];
	int unsigned requests_sent = 0;
	int unsigned results_taken = 0;
	bit          send_burst    = 1'b0;
	bit          recv_burst    = 1'b0;

	json_string_escaper_utf8 i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	json_literal_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.item           (item),
		.full           (full),
		.empty          (empty),
		.pop            (pop),
		.result         (result),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("** json_string_escaper_utf8: FAILED **");
		$finish;
	end

	function automatic jse_pkg::in_item_t mk_req(input logic [7:0] data, input logic present,
			input logic is_start, input logic is_end);
		jse_pkg::in_item_t r;
		r.data_byte    = data;
		r.byte_present = present;
		r.string_start = is_start;
		r.string_end   = is_end;
		return r;
	endfunction

	// Offers one request after a random gap and returns once it is taken.
	task automatic send_req(input jse_pkg::in_item_t req, input bit counted);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= req;
		@(negedge clk);
		while (full) @(negedge clk);
		@(posedge clk);
		if (counted)
			requests_sent++;
	endtask

	// Sends the bytes in text_q as one string. Start and end may ride on the
	// first and last byte or on separate requests with no byte; an unclosed
	// string is left open for the next start to cut off.
	task automatic send_string(input bit lead_mark, input bit trail_mark, input bit closed);
		int  n;
		bit  start_on_byte;
		n = text_q.size();
		start_on_byte = !lead_mark && n > 0;
		if (!start_on_byte)
			send_req(mk_req(8'($urandom_range(0, 255)), 1'b0, 1'b1,
				n == 0 && closed && !trail_mark), 1'b1);
		for (int i = 0; i < n; i++)
			send_req(mk_req(text_q[i], 1'b1, i == 0 && start_on_byte,
				i == n - 1 && closed && !trail_mark), 1'b1);
		if (closed && trail_mark)
			send_req(mk_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1), 1'b1);
		text_q.delete();
	endtask

	// Appends a multi-byte sequence, mostly well formed, with the edge leads
	// favored. Some are cut short or get a bad continuation byte.
	task automatic add_utf8_seq();
		logic [7:0] seq_q [$];
		logic [7:0] lead;
		logic [7:0] nxt;
		logic [7:0] lo;
		logic [7:0] hi;
		int         total;
		int         pick;
		total = $urandom_range(2, 4);
		pick  = $urandom_range(0, 3);
		case (total)
			2: lead = 8'($urandom_range(8'hC2, 8'hDF));
			3: lead = (pick == 0) ? 8'hE0 : (pick == 1) ? 8'hED :
				8'($urandom_range(8'hE0, 8'hEF));
			default: lead = (pick == 0) ? 8'hF0 : (pick == 1) ? 8'hF4 :
				8'($urandom_range(8'hF0, 8'hF4));
		endcase
		lo = 8'h80;
		hi = 8'hBF;
		if (lead == 8'hE0) lo = 8'hA0;
		if (lead == 8'hED) hi = 8'h9F;
		if (lead == 8'hF0) lo = 8'h90;
		if (lead == 8'hF4) hi = 8'h8F;
		seq_q = {seq_q, lead};
		nxt = 8'($urandom_range(lo, hi));
		seq_q = {seq_q, nxt};
		while (seq_q.size() < total) begin
			nxt = 8'($urandom_range(8'h80, 8'hBF));
			seq_q = {seq_q, nxt};
		end
		if ($urandom_range(0, 4) == 0) begin
			if ($urandom_range(0, 1) == 0) begin
				seq_q.delete(seq_q.size() - 1);
			end else begin
				nxt = 8'($urandom_range(0, 255));
				seq_q[$urandom_range(1, seq_q.size() - 1)] = nxt;
			end
		end
		text_q = {text_q, seq_q};
	endtask

	task automatic add_random_char();
		logic [7:0] ch;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			ch = 8'($urandom_range(8'h20, 8'h7E));
		end else if (r < 45) begin
			case ($urandom_range(0, 7))
				0: ch = 8'h22;
				1: ch = 8'h5C;
				2: ch = 8'h3C;
				3: ch = 8'h3E;
				4: ch = 8'h26;
				5: ch = 8'h0A;
				6: ch = 8'h0D;
				default: ch = 8'h09;
			endcase
		end else if (r < 52) begin
			ch = 8'($urandom_range(8'h00, 8'h1F));
		end else if (r < 80) begin
			add_utf8_seq();
			return;
		end else begin
			ch = 8'($urandom_range(0, 255));
		end
		text_q = {text_q, ch};
	endtask

	// Receiver: pops with random holds, and once holds off for a long
	// stretch so that the block fills up and raises full.
	initial begin
		int  hold;
		bit  long_hold_done;
		long_hold_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (results_taken % 30 == 0 && $urandom_range(0, 3) == 0)
				recv_burst = !recv_burst;
			hold = recv_burst ? 0 : $urandom_range(0, 9);
			if (!long_hold_done && results_taken == 120) begin
				hold = 400;
				long_hold_done = 1'b1;
			end
			if (hold != 0) begin
				pop <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			pop <= 1'b1;
			@(negedge clk);
			while (empty) @(negedge clk);
			@(posedge clk);
			results_taken++;
		end
	end

	// Reset, directed strings, random strings, then drain and give the verdict.
	initial begin
		bit lead_mark;
		bit trail_mark;
		bit closed;
		bit open_now;
		int len;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty string on one request, then a request with no string open.
		send_string(1'b0, 1'b0, 1'b1);
		send_req(mk_req(8'h41, 1'b1, 1'b0, 1'b0), 1'b0);

		// Field extremes and every single-byte escape, with a lone
		// continuation byte on the closing request.
		text_q = '{8'h00, 8'h1F, 8'h22, 8'h5C, 8'h3C, 8'h3E, 8'h26, 8'h0A, 8'h0D,
			8'h09, 8'h20, 8'h7F, 8'hFF, 8'h80};
		send_string(1'b0, 1'b0, 1'b1);

		// A failed second byte, a valid four-byte sequence, then a new start
		// that cuts off a held lead, and an end with a truncated sequence.
		text_q = '{8'hE0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hC2};
		send_string(1'b0, 1'b0, 1'b0);
		text_q = '{8'hC3};
		send_string(1'b0, 1'b1, 1'b1);

		// Random strings, mostly well formed, with framing variations.
		open_now = 1'b0;
		while (requests_sent < 315) begin
			if ($urandom_range(0, 5) == 0)
				send_burst = !send_burst;
			if (!open_now && $urandom_range(0, 7) == 0)
				send_req(mk_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'b0, 1'($urandom_range(0, 1))), 1'b0);
			len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
			for (int i = 0; i < len; i++)
				add_random_char();
			lead_mark  = ($urandom_range(0, 4) == 0);
			trail_mark = ($urandom_range(0, 4) == 0);
			closed     = ($urandom_range(0, 7) != 0);
			send_string(lead_mark, trail_mark, closed);
			open_now = !closed;
		end
		push <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("** json_string_escaper_utf8: PASSED **");
		else
			$display("** json_string_escaper_utf8: FAILED **");
		$finish;
	end

endmodule
